FILE: sv/month_calendar_grid_macros.svh
// assertion macros shared by the calendar grid checker
// no dependencies; take in with `include
`ifndef MONTH_CALENDAR_GRID_MACROS_SVH
`define MONTH_CALENDAR_GRID_MACROS_SVH

// same-cycle implication, checked outside reset
`define MCG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define MCG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/mcg_pkg.sv
// shared types, constants and tables of the month calendar grid
// no dependencies
`default_nettype none

package mcg_pkg;

    localparam logic [11:0] BASE_YEAR  = 12'd1583;
    // leap years in 1..1582
    localparam logic [12:0] LEAPS_BASE = 13'd383;
    localparam logic [3:0]  LAST_MONTH = 4'd11;
    localparam logic [3:0]  FEBRUARY   = 4'd1;
    localparam logic [3:0]  MARCH      = 4'd2;

    // floor(p / 100) = (p * 5243) >> 19 for any 12-bit p
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int          SHIFT_100 = 19;
    // floor(x / 7) = (x * 2341) >> 14 for any 12-bit x
    localparam logic [11:0] RECIP_7   = 12'd2341;
    localparam int          SHIFT_7   = 14;

    typedef struct packed {
        logic load;
        logic mul;
        logic sum;
        logic div;
        logic rem;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic month_ok;
        logic last_day;
    } t_status;

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd1:                      len = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] month_before(input logic [3:0] m);
        logic [8:0] days;
        unique case (m)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd31;
            4'd2:    days = 9'd59;
            4'd3:    days = 9'd90;
            4'd4:    days = 9'd120;
            4'd5:    days = 9'd151;
            4'd6:    days = 9'd181;
            4'd7:    days = 9'd212;
            4'd8:    days = 9'd243;
            4'd9:    days = 9'd273;
            4'd10:   days = 9'd304;
            4'd11:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

`default_nettype wire

FILE: sv/mcg_ctrl.sv
// controller of the month calendar grid: sequences the weekday steps and the day beats
// depends on mcg_pkg
`default_nettype none

module mcg_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic           i_ready,
    input  wire mcg_pkg::t_status i_status,
    output logic                o_ready,
    output logic                o_valid,
    output mcg_pkg::t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_DIV,
        S_REM,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   in_beat;
    logic   out_beat;

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign in_beat  = i_valid && o_ready;
    assign out_beat = r_out_valid && i_ready;

    always_comb begin
        o_cmd      = '0;
        o_cmd.load = in_beat;
        o_cmd.mul  = (r_state == S_MUL);
        o_cmd.sum  = (r_state == S_SUM);
        o_cmd.div  = (r_state == S_DIV);
        o_cmd.rem  = (r_state == S_REM);
        o_cmd.step = out_beat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    // an out-of-range month gives no beats
                    if (in_beat && i_status.month_ok) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_SUM;
                S_SUM: r_state <= S_DIV;
                S_DIV: r_state <= S_REM;
                S_REM: begin
                    r_state     <= S_EMIT;
                    r_out_valid <= 1'b1;
                end
                S_EMIT: begin
                    if (out_beat && i_status.last_day) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b0;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: sv/mcg_datapath.sv
// datapath of the month calendar grid: weekday of the first, then day and cell counters
// depends on mcg_pkg
`default_nettype none

module mcg_datapath (
    input  wire logic           i_clk,
    input  wire logic [11:0]    i_year,
    input  wire logic [3:0]     i_month,
    input  wire mcg_pkg::t_cmd  i_cmd,
    output mcg_pkg::t_status    o_status,
    output logic [4:0]          o_day_number,
    output logic [5:0]          o_cell_index,
    output logic                o_last
);

    logic [11:0] r_year;
    logic [3:0]  r_month;
    logic [11:0] r_p;
    logic [5:0]  r_q;
    logic        r_leap;
    logic [11:0] r_sum;
    logic [9:0]  r_q7;
    logic [4:0]  r_day;
    logic [5:0]  r_cell;
    logic [4:0]  r_len;

    logic [11:0] year_c;
    logic [24:0] prod100;
    logic [6:0]  rem100;
    logic [5:0]  q_plus;
    logic        n_leap;
    logic [12:0] n_sum;
    logic [23:0] prod7;
    logic [2:0]  mod7;
    logic [2:0]  col;

    assign year_c = (i_year < mcg_pkg::BASE_YEAR) ? mcg_pkg::BASE_YEAR : i_year;

    // q = floor((year - 1) / 100)
    assign prod100 = 25'(r_p) * 25'(mcg_pkg::RECIP_100);

    // year is a century year exactly when (year - 1) mod 100 is 99
    assign rem100 = 7'(r_p - (12'(r_q) * 12'd100));
    assign q_plus = r_q + 6'd1;
    assign n_leap = (r_year[1:0] == 2'd0) && ((rem100 != 7'd99) || (q_plus[1:0] == 2'd0));

    // day count since the base year, only its value mod 7 matters later
    assign n_sum = 13'(r_year - mcg_pkg::BASE_YEAR) + 13'(r_p[11:2]) + 13'(r_q[5:2])
                 + 13'(mcg_pkg::month_before(r_month))
                 + 13'(n_leap && (r_month >= mcg_pkg::MARCH))
                 - 13'(r_q) - mcg_pkg::LEAPS_BASE;

    assign prod7 = 24'(r_sum) * 24'(mcg_pkg::RECIP_7);
    assign mod7  = 3'(r_sum - (12'(r_q7) * 12'd7));
    // base day is a saturday
    assign col   = (mod7 == 3'd0) ? 3'd6 : 3'(mod7 - 3'd1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_year  <= year_c;
            r_month <= i_month;
            r_p     <= year_c - 12'd1;
        end
        if (i_cmd.mul) begin
            r_q <= 6'(prod100 >> mcg_pkg::SHIFT_100);
        end
        if (i_cmd.sum) begin
            r_sum  <= 12'(n_sum);
            r_leap <= n_leap;
        end
        if (i_cmd.div) begin
            r_q7 <= 10'(prod7 >> mcg_pkg::SHIFT_7);
        end
        if (i_cmd.rem) begin
            r_day  <= 5'd1;
            r_cell <= 6'(col);
            r_len  <= mcg_pkg::month_len(r_month)
                    + 5'(r_leap && (r_month == mcg_pkg::FEBRUARY));
        end else if (i_cmd.step) begin
            // row * 7 + column moves by one cell per day
            r_day  <= r_day + 5'd1;
            r_cell <= r_cell + 6'd1;
        end
    end

    assign o_status.month_ok = (i_month <= mcg_pkg::LAST_MONTH);
    assign o_status.last_day = (r_day == r_len);
    assign o_day_number      = r_day;
    assign o_cell_index      = r_cell;
    assign o_last            = (r_day == r_len);

endmodule

`default_nettype wire

FILE: sv/month_calendar_grid.sv
// channel   direction   signals                                       payload
// request   in          i_valid / o_ready                             i_year, i_month
// day       out         o_valid / i_ready                             o_day_number, o_cell_index, o_last
//
// after a request is taken, the weekday of the first is found (one reciprocal multiply
// for the century count, one sum, one reciprocal multiply and a subtract for mod 7),
// then gives 28 to 31 day beats, one per cycle while i_ready is high
// a request with a month above 11 is taken and gives no beats
// the next request is taken once the last day beat has gone; o_ready is low meanwhile
// reset (i_rst_n low at a clock edge) returns the controller to idle with no beat pending
// depends on mcg_pkg, mcg_ctrl, mcg_datapath
`default_nettype none

module month_calendar_grid (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [11:0]    i_year,
    input  wire logic [3:0]     i_month,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [4:0]          o_day_number,
    output logic [5:0]          o_cell_index,
    output logic                o_last
);

    mcg_pkg::t_cmd    cmd;
    mcg_pkg::t_status status;

    mcg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .o_cmd    (cmd)
    );

    mcg_datapath u_datapath (
        .i_clk        (i_clk),
        .i_year       (i_year),
        .i_month      (i_month),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_day_number (o_day_number),
        .o_cell_index (o_cell_index),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

FILE: sv/month_calendar_grid_checker.sv
// port-level checks of the month calendar grid, bound to the top level
// depends on month_calendar_grid_macros.svh and month_calendar_grid
`default_nettype none
`include "month_calendar_grid_macros.svh"

module month_calendar_grid_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_valid,
    input wire logic           o_ready,
    input wire logic [11:0]    i_year,
    input wire logic [3:0]     i_month,
    input wire logic           o_valid,
    input wire logic           i_ready,
    input wire logic [4:0]     o_day_number,
    input wire logic [5:0]     o_cell_index,
    input wire logic           o_last
);

    // a waiting request beat holds
    `MCG_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_valid && !o_ready, i_valid && $stable(i_year) && $stable(i_month))

    // a stalled day beat holds
    `MCG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_day_number) && $stable(o_cell_index) && $stable(o_last))

    // no new request while day beats are pending
    `MCG_ASSERT_IMPL(a_one_at_a_time, i_clk, i_rst_n, o_valid, !o_ready)

    // the last day ends the burst
    `MCG_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, o_valid && i_ready && o_last, !o_valid)

    // days and cells advance together by one
    `MCG_ASSERT_NEXT(a_day_step, i_clk, i_rst_n, o_valid && i_ready && !o_last, o_valid && (o_day_number == 5'($past(o_day_number) + 5'd1)) && (o_cell_index == 6'($past(o_cell_index) + 6'd1)))

endmodule

bind month_calendar_grid month_calendar_grid_checker u_checker (.*);

`default_nettype wire

FILE: sim/tb_top.sv
// testbench for month_calendar_grid: random and directed year/month requests
// with a day-beat scoreboard class that predicts every grid cell
// depends on mcg_pkg and month_calendar_grid
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 12;
    // random in-range months; directed and out-of-range requests come on top
    localparam int ITEM_TARGET  = 410;
    localparam int IDLE_PCT     = 21;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 2000;

    typedef struct packed {
        logic [4:0] day;
        logic [5:0] grid_pos;
        logic       last;
    } t_day_beat;

    // predicts the day beats of each accepted request and checks them in order
    class day_grid_checker;
        t_day_beat pending_days[$];
        int        errors;
        int        beats_seen;
        int        months_laid;
        int        months_ignored;

        function new();
            errors         = 0;
            beats_seen     = 0;
            months_laid    = 0;
            months_ignored = 0;
        endfunction

        function int unsigned days_in_month(int unsigned m, bit leap);
            int unsigned n;
            case (m)
                1:             n = leap ? 29 : 28;
                3, 5, 8, 10:   n = 30;
                default:       n = 31;
            endcase
            return n;
        endfunction

        function int unsigned leaps_through(int unsigned y);
            return y / 4 - y / 100 + y / 400;
        endfunction

        function void note_request(logic [11:0] year, logic [3:0] month);
            int unsigned y;
            int unsigned span;
            int unsigned first_col;
            int unsigned len;
            int unsigned m;
            bit          leap;
            t_day_beat   beat;
            if (month > mcg_pkg::LAST_MONTH) begin
                months_ignored++;
                return;
            end
            months_laid++;
            // years before the base are laid out as the base year
            y = (year < mcg_pkg::BASE_YEAR) ? mcg_pkg::BASE_YEAR : year;
            leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
            span = 365 * (y - mcg_pkg::BASE_YEAR) + leaps_through(y - 1)
                 - leaps_through(mcg_pkg::BASE_YEAR - 1);
            for (m = 0; m < month; m++)
                span += days_in_month(m, leap);
            // 1 jan of the base year fell on a saturday
            first_col = (span % 7 + 6) % 7;
            len = days_in_month(month, leap);
            for (int unsigned d = 1; d <= len; d++) begin
                beat.day      = d[4:0];
                beat.grid_pos = 6'(first_col + d - 1);
                beat.last     = (d == len);
                pending_days.push_back(beat);
            end
        endfunction

        function void check_day(logic [4:0] day, logic [5:0] grid_pos, logic last);
            t_day_beat want;
            if (pending_days.size() == 0) begin
                $display("%0t: day beat with none pending: day %0d cell %0d last %0b",
                         $time, day, grid_pos, last);
                errors++;
                return;
            end
            want = pending_days.pop_front();
            beats_seen++;
            if (day !== want.day) begin
                $display("%0t: day_number expected %0d actual %0d", $time, want.day, day);
                errors++;
            end
            if (grid_pos !== want.grid_pos) begin
                $display("%0t: cell_index expected %0d actual %0d (day %0d)",
                         $time, want.grid_pos, grid_pos, want.day);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: last expected %0b actual %0b (day %0d)",
                         $time, want.last, last, want.day);
                errors++;
            end
        endfunction

        function int waiting();
            return pending_days.size();
        endfunction
    endclass

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [11:0] i_year  = '0;
    logic [3:0]  i_month = '0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [4:0]  o_day_number;
    logic [5:0]  o_cell_index;
    logic        o_last;

    bit calm          = 1'b0;
    bit hold_request  = 1'b0;

    day_grid_checker book = new();

    month_calendar_grid dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_year       (i_year),
        .i_month      (i_month),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_day_number (o_day_number),
        .o_cell_index (o_cell_index),
        .o_last       (o_last)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // day beat monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            book.check_day(o_day_number, o_cell_index, o_last);
    end

    // receiver: random stalls, a calm stretch, and one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // ends the run if no beat moves on either side for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // offer one request and hold it until taken; valid stays high afterward
    task automatic offer_request(input logic [11:0] year, input logic [3:0] month);
        i_valid <= 1'b1;
        i_year  <= year;
        i_month <= month;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        book.note_request(year, month);
    endtask

    task automatic sender_gap();
        int n;
        n = 0;
        if (!calm && $urandom_range(0, 99) < IDLE_PCT)
            n = $urandom_range(1, 12);
        if (n > 0) begin
            i_valid <= 1'b0;
            i_year  <= 12'($urandom);
            i_month <= 4'($urandom);
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_request(input logic [11:0] year, input logic [3:0] month);
        offer_request(year, month);
        sender_gap();
    endtask

    function automatic logic [11:0] pick_year();
        int unsigned r;
        logic [11:0] y;
        r = $urandom_range(0, 99);
        if (r < 78)
            y = 12'($urandom_range(1583, 4040));
        else if (r < 86)
            y = 12'($urandom_range(0, 1582));
        else if (r < 94)
            y = 12'($urandom_range(4041, 4095));
        else
            y = 12'($urandom_range(16, 40) * 100);
        return y;
    endfunction

    initial begin
        int          sent;
        logic [11:0] year;
        logic [3:0]  month;
        sent = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: range ends, clamped years, century leap rules, ignored months
        send_request(12'd1583, 4'd0);
        send_request(12'd1583, 4'd11);
        send_request(12'd0,    4'd0);
        send_request(12'd1582, 4'd1);
        send_request(12'd4040, 4'd11);
        send_request(12'd4040, 4'd1);
        send_request(12'd4095, 4'd1);
        send_request(12'd4095, 4'd11);
        send_request(12'd2000, 4'd1);
        send_request(12'd1900, 4'd1);
        send_request(12'd1600, 4'd2);
        send_request(12'd1700, 4'd2);
        send_request(12'd2024, 4'd1);
        send_request(12'd2023, 4'd1);
        send_request(12'd2047, 4'd3);
        send_request(12'd2730, 4'd5);
        send_request(12'd1365, 4'd8);
        send_request(12'd3000, 4'd9);
        send_request(12'd3333, 4'd10);
        send_request(12'd2222, 4'd4);
        send_request(12'd1234, 4'd7);
        send_request(12'd2100, 4'd6);
        send_request(12'd2000, 4'd12);
        send_request(12'd4095, 4'd15);
        send_request(12'd1583, 4'd13);

        while (sent < ITEM_TARGET) begin
            year = pick_year();
            if ($urandom_range(0, 99) < 6)
                month = 4'($urandom_range(12, 15));
            else
                month = 4'($urandom_range(0, 11));
            calm = (sent >= 150 && sent < 250);
            if (sent == 300 && month <= mcg_pkg::LAST_MONTH)
                hold_request = 1'b1;
            // pause until every day beat has come out
            if (sent == 380 && month <= mcg_pkg::LAST_MONTH) begin
                i_valid <= 1'b0;
                while (book.waiting() != 0) @(posedge i_clk);
                @(posedge i_clk);
            end
            send_request(year, month);
            if (month <= mcg_pkg::LAST_MONTH)
                sent++;
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        while (book.waiting() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d months laid out, %0d out-of-range months dropped",
                 book.months_laid, book.months_ignored);
        $display("summary: %0d day beats checked, %0d mismatches",
                 book.beats_seen, book.errors);
        if (book.errors == 0 && book.waiting() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
